/* rtl/brb_pkg.sv */
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer: request codes,
// word layouts of both channels and the sequencer states.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int MAX_XFER_DEF = 64;
    localparam int DATA_W       = 8;
    localparam int LEN_W        = 7;
    localparam int OCC_W        = 11;

    // request codes
    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    // input word
    typedef struct packed {
        req_t               req_type;
        logic [LEN_W-1:0]   length;
        logic [DATA_W-1:0]  data_in;
        logic               run_end;
    } brb_in_t;

    // result word
    typedef struct packed {
        logic               status;
        logic [DATA_W-1:0]  data_out;
        logic               last;
        logic [OCC_W-1:0]   occupancy;
    } brb_out_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA
    } state_t;

endpackage

/* rtl/brb_store.sv */
// ----------------------------------------------------------------------------
// brb_store
// Byte store of the ring buffer: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module brb_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [brb_pkg::DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [brb_pkg::DATA_W-1:0] rd_data
);
    import brb_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/brb_outreg.sv */
// ----------------------------------------------------------------------------
// brb_outreg
// Result register of the ring buffer: holds one result word until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module brb_outreg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  brb_pkg::brb_out_t load_word,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output brb_pkg::brb_out_t m_item
);
    import brb_pkg::*;

    logic     valid_reg;
    brb_out_t word_reg;

    // register can take a new word when empty or being drained
    assign free = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= load_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = word_reg;

endmodule

/* rtl/byte_ring_buffer_core.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer_core
// Circular byte FIFO with all-or-nothing multi-byte push, pop and peek.
// ----------------------------------------------------------------------------
// A push byte word is taken and written straight into the store; a run's
// admission is decided on its first word and its status word comes with the
// run's final word. Clear and any refused pop or peek also give a single
// result word, loaded in the cycle they are accepted. An allowed pop or peek
// of N bytes is accepted and then read out byte by byte: a small sequencer
// drives one shared wrap-around position incrementer and the single read port
// of the store, issuing each read in ST_RD_ADDR and loading the registered
// read data into the result register in ST_RD_DATA. Stalls on the result side
// hold the sequencer there. No new word is taken while a pop or peek is being
// read out or while the result register is full and not being drained.
// ----------------------------------------------------------------------------
module byte_ring_buffer_core #(
    parameter int CAPACITY = brb_pkg::CAPACITY_DEF,
    parameter int MAX_XFER = brb_pkg::MAX_XFER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brb_pkg::brb_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output brb_pkg::brb_out_t m_item
);
    import brb_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > LEN_W) ? FW : LEN_W;

    state_t            state_reg, state_next;
    logic [PW-1:0]     read_pos_reg, read_pos_next;
    logic [PW-1:0]     write_pos_reg, write_pos_next;
    logic [PW-1:0]     cur_pos_reg, cur_pos_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              is_pop_reg, is_pop_next;
    logic              in_push_run_reg, in_push_run_next;
    logic              run_refused_reg, run_refused_next;

    logic              accept;
    logic              out_free;
    logic              load;
    brb_out_t          load_word;
    logic              wr_en;
    logic              rd_en;
    logic [DATA_W-1:0] rd_data;

    logic [PW-1:0]     inc_in;
    logic [PW-1:0]     inc_out;
    logic [CW-1:0]     len_ext;
    logic [CW-1:0]     fill_ext;
    logic [CW-1:0]     free_space;
    logic              len_bad;
    logic              push_refused;
    logic              room;

    // shared wrap-around position incrementer
    assign inc_in  = (state_reg == ST_IDLE) ? write_pos_reg : cur_pos_reg;
    assign inc_out = (inc_in == PW'(CAPACITY - 1)) ? '0 : inc_in + PW'(1);

    // length and space checks
    assign len_ext    = CW'(s_item.length);
    assign fill_ext   = CW'(fill_reg);
    assign free_space = CW'(CAPACITY) - fill_ext;
    assign len_bad    = (s_item.length == '0) || (s_item.length > LEN_W'(MAX_XFER));
    assign push_refused = in_push_run_reg ? run_refused_reg
                                          : (len_bad || (free_space < len_ext));
    assign room       = (fill_reg < FW'(CAPACITY));

    assign s_ready = (state_reg == ST_IDLE) && out_free;
    assign accept  = s_valid && s_ready;

    // state and position registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            read_pos_reg    <= '0;
            write_pos_reg   <= '0;
            fill_reg        <= '0;
            in_push_run_reg <= 1'b0;
            run_refused_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            read_pos_reg    <= read_pos_next;
            write_pos_reg   <= write_pos_next;
            fill_reg        <= fill_next;
            in_push_run_reg <= in_push_run_next;
            run_refused_reg <= run_refused_next;
        end
    end

    // transfer working registers
    always_ff @(posedge aclk) begin
        cur_pos_reg <= cur_pos_next;
        cnt_reg     <= cnt_next;
        is_pop_reg  <= is_pop_next;
    end

    // sequencer: next state and outputs
    always_comb begin
        state_next       = state_reg;
        read_pos_next    = read_pos_reg;
        write_pos_next   = write_pos_reg;
        fill_next        = fill_reg;
        in_push_run_next = in_push_run_reg;
        run_refused_next = run_refused_reg;
        cur_pos_next     = cur_pos_reg;
        cnt_next         = cnt_reg;
        is_pop_next      = is_pop_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        load             = 1'b0;
        load_word        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_item.req_type)
                        REQ_PUSH: begin
                            // store the byte if the run is admitted and there is room
                            if (!push_refused && room) begin
                                wr_en          = 1'b1;
                                write_pos_next = inc_out;
                                fill_next      = fill_reg + FW'(1);
                            end
                            if (s_item.run_end) begin
                                in_push_run_next = 1'b0;
                                run_refused_next = 1'b0;
                                load             = 1'b1;
                                load_word.status = push_refused;
                                load_word.last   = 1'b1;
                                load_word.occupancy = OCC_W'(fill_next);
                            end else begin
                                in_push_run_next = 1'b1;
                                run_refused_next = push_refused;
                            end
                        end
                        REQ_CLEAR: begin
                            in_push_run_next = 1'b0;
                            run_refused_next = 1'b0;
                            read_pos_next    = '0;
                            write_pos_next   = '0;
                            fill_next        = '0;
                            load             = 1'b1;
                            load_word.last   = 1'b1;
                        end
                        REQ_POP, REQ_PEEK: begin
                            in_push_run_next = 1'b0;
                            run_refused_next = 1'b0;
                            if (len_bad || (fill_ext < len_ext)) begin
                                load                = 1'b1;
                                load_word.status    = 1'b1;
                                load_word.last      = 1'b1;
                                load_word.occupancy = OCC_W'(fill_reg);
                            end else begin
                                // start the read-out loop
                                cur_pos_next = read_pos_reg;
                                cnt_next     = s_item.length;
                                is_pop_next  = (s_item.req_type == REQ_POP);
                                if (s_item.req_type == REQ_POP) begin
                                    fill_next = fill_reg - FW'(s_item.length);
                                end
                                state_next = ST_RD_ADDR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_ADDR: begin
                rd_en      = 1'b1;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                if (out_free) begin
                    load                = 1'b1;
                    load_word.data_out  = rd_data;
                    load_word.last      = (cnt_reg == LEN_W'(1));
                    load_word.occupancy = OCC_W'(fill_reg);
                    cur_pos_next        = inc_out;
                    cnt_next            = cnt_reg - LEN_W'(1);
                    if (cnt_reg == LEN_W'(1)) begin
                        if (is_pop_reg) begin
                            read_pos_next = inc_out;
                        end
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RD_ADDR;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    brb_store #(
        .DEPTH (CAPACITY),
        .AW    (PW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (write_pos_reg),
        .wr_data (s_item.data_in),
        .rd_en   (rd_en),
        .rd_addr (cur_pos_reg),
        .rd_data (rd_data)
    );

    brb_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .load_word (load_word),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // pointer distance, used by the checks below
    logic [PW-1:0] ptr_dist;
    assign ptr_dist = (write_pos_reg >= read_pos_reg)
                    ? (write_pos_reg - read_pos_reg)
                    : (write_pos_reg + PW'(CAPACITY) - read_pos_reg);

    // occupancy never beyond capacity
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(CAPACITY))
        else $error("fill count beyond capacity");

    // pointers agree with the fill count between requests
    a_ptr_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |->
            ((fill_reg == FW'(CAPACITY)) ? (ptr_dist == '0)
                                         : (FW'(ptr_dist) == fill_reg)))
        else $error("pointers disagree with fill count");

    // a result word is only loaded into a free register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("result register overwritten");

    // read-out loop always has bytes left
    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_ADDR || state_reg == ST_RD_DATA) |-> (cnt_reg != '0))
        else $error("read-out loop with zero count");

    // refusal flag only lives inside a push run
    a_refused_run: assert property (@(posedge aclk) disable iff (!aresetn)
        run_refused_reg |-> in_push_run_reg)
        else $error("refused flag outside a push run");

endmodule

/* test/byte_ring_buffer_core_tb.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer_core_tb
// Self-checking bench for the byte ring buffer core: directed push, pop, peek
// and clear words, then random request streams, first with random idling on
// both channels and then without. Every result word is checked against a
// behavioral ring model kept in the bench.
// ----------------------------------------------------------------------------
module byte_ring_buffer_core_tb;

    import brb_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int MAX_LEN      = MAX_XFER_DEF;
    localparam int RAND_ITEMS   = 290;
    localparam int CALM_ITEMS   = 55;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 300;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    brb_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    brb_out_t m_item;

    // ring model state
    logic [DATA_W-1:0] ring_mem [0:CAP-1];
    int        rd_pos     = 0;
    int        wr_pos     = 0;
    int        fill_cnt   = 0;
    bit        in_run     = 1'b0;
    bit        run_drop   = 1'b0;
    brb_out_t  pending_words [$];

    int  err_count   = 0;
    int  words_seen  = 0;
    int  items_sent  = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  idle_on     = 1'b1;

    byte_ring_buffer_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // queue one expected result word with the current occupancy
    function automatic void add_expect(input bit status, input logic [DATA_W-1:0] data,
                                       input bit last);
        brb_out_t w;
        w.status    = status;
        w.data_out  = data;
        w.last      = last;
        w.occupancy = fill_cnt[OCC_W-1:0];
        pending_words.push_back(w);
    endfunction

    // advance the ring model by one accepted request word
    function automatic void apply_request(input brb_in_t w);
        int len;
        int pos;
        len = int'(w.length);
        if (w.req_type == REQ_PUSH) begin
            // admission is decided on the first word of a run
            if (!in_run) begin
                in_run   = 1'b1;
                run_drop = (len == 0) || (len > MAX_LEN) || (CAP - fill_cnt < len);
            end
            if (!run_drop && fill_cnt < CAP) begin
                ring_mem[wr_pos] = w.data_in;
                wr_pos = (wr_pos + 1 >= CAP) ? 0 : wr_pos + 1;
                fill_cnt++;
            end
            if (w.run_end) begin
                in_run = 1'b0;
                add_expect(run_drop, '0, 1'b1);
                run_drop = 1'b0;
            end
        end else begin
            // any other request ends an open run silently
            in_run   = 1'b0;
            run_drop = 1'b0;
            if (w.req_type == REQ_CLEAR) begin
                rd_pos   = 0;
                wr_pos   = 0;
                fill_cnt = 0;
                add_expect(1'b0, '0, 1'b1);
            end else if (len == 0 || len > MAX_LEN || fill_cnt < len) begin
                add_expect(1'b1, '0, 1'b1);
            end else begin
                pos = rd_pos;
                if (w.req_type == REQ_POP)
                    fill_cnt -= len;
                for (int i = 0; i < len; i++) begin
                    add_expect(1'b0, ring_mem[pos], i == len - 1);
                    pos = (pos + 1 >= CAP) ? 0 : pos + 1;
                end
                if (w.req_type == REQ_POP)
                    rd_pos = pos;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR word %0d %s: got 0x%0h expected 0x%0h", words_seen, what, got, want);
        err_count++;
    endtask

    // compare one result word with the oldest expectation
    task automatic check_word(input brb_out_t got);
        brb_out_t want;
        if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", int'(got), 0);
        end else begin
            want = pending_words.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", int'(got.status), int'(want.status));
            if (got.data_out !== want.data_out)
                report_mismatch("data_out", int'(got.data_out), int'(want.data_out));
            if (got.last !== want.last)
                report_mismatch("last", int'(got.last), int'(want.last));
            if (got.occupancy !== want.occupancy)
                report_mismatch("occupancy", int'(got.occupancy), int'(want.occupancy));
        end
        words_seen++;
    endtask

    // result side: check accepted words and stall ready in bursts
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                check_word(m_item);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left <= $urandom_range(1, 4) - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // send one request word; valid stays high for a following word
    task automatic send_req(input req_t req, input int len, input logic [DATA_W-1:0] data,
                            input bit run_end);
        brb_in_t w;
        w.req_type = req;
        w.length   = len[LEN_W-1:0];
        w.data_in  = data;
        w.run_end  = run_end;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= w;
        do @(posedge aclk); while (!s_ready);
        apply_request(w);
        items_sent++;
    endtask

    // push run of nbytes words with random data
    task automatic push_run(input int len, input int nbytes, input bit with_end);
        for (int i = 0; i < nbytes; i++)
            send_req(REQ_PUSH, len, 8'($urandom_range(0, 255)),
                     with_end && (i == nbytes - 1));
    endtask

    // pop, peek or clear with random filler in the unused fields
    task automatic send_read(input req_t req, input int len);
        send_req(req, len, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    function automatic int bad_len();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_LEN + 1, 127);
    endfunction

    function automatic int pick_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(17, MAX_LEN)
                                           : $urandom_range(1, 16);
    endfunction

    task automatic test_directed();
        // reads on an empty store are refused
        send_read(REQ_POP, 1);
        send_read(REQ_PEEK, 1);
        // single byte and a short run with extreme data
        send_req(REQ_PUSH, 1, 8'h00, 1'b1);
        send_req(REQ_PUSH, 3, 8'hff, 1'b0);
        send_req(REQ_PUSH, 3, 8'ha5, 1'b0);
        send_req(REQ_PUSH, 3, 8'h5a, 1'b1);
        send_read(REQ_PEEK, 4);
        send_read(REQ_PEEK, 5);
        send_read(REQ_POP, 2);
        // illegal read lengths
        send_read(REQ_POP, 0);
        send_read(REQ_PEEK, 127);
        send_read(REQ_POP, MAX_LEN + 1);
        // illegal push lengths drop the run
        send_req(REQ_PUSH, 0, 8'h81, 1'b1);
        send_req(REQ_PUSH, 127, 8'h7e, 1'b1);
        // run longer than its length keeps storing while there is room
        push_run(2, 3, 1'b1);
        // run cut short by a peek
        push_run(4, 2, 1'b0);
        send_read(REQ_PEEK, 1);
        // run cut short by a clear
        push_run(2, 1, 1'b0);
        send_read(REQ_CLEAR, 1);
        send_read(REQ_POP, 1);
    endtask

    // one random request: mostly well-formed runs and reads, some noise
    task automatic random_request();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (fill_cnt > 800 && pick < 45)
            pick += 45;
        if (pick < 45) begin
            len = pick_len();
            push_run(len, len, 1'b1);
        end else if (pick < 85) begin
            if (fill_cnt > 0 && $urandom_range(0, 5) != 0)
                len = $urandom_range(1, (fill_cnt < MAX_LEN) ? fill_cnt : MAX_LEN);
            else
                len = pick_len();
            send_read((pick < 70) ? REQ_POP : REQ_PEEK, len);
        end else if (pick < 88) begin
            send_read(REQ_CLEAR, $urandom_range(0, 127));
        end else begin
            len = pick_len();
            case ($urandom_range(0, 4))
                0: push_run(bad_len(), $urandom_range(1, 3), 1'b1);
                1: push_run(len, $urandom_range(1, len), 1'b0);
                2: push_run(len, len + $urandom_range(1, 3), 1'b1);
                3: send_read($urandom_range(0, 1) ? REQ_POP : REQ_PEEK, bad_len());
                default: begin
                    if (fill_cnt < MAX_LEN)
                        len = $urandom_range(fill_cnt + 1, MAX_LEN);
                    else
                        len = bad_len();
                    send_read($urandom_range(0, 1) ? REQ_POP : REQ_PEEK, len);
                end
            endcase
        end
    endtask

    task automatic test_random(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            random_request();
    endtask

    task automatic test_random_calm(input int n_items);
        idle_on = 1'b0;
        test_random(n_items);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(RAND_ITEMS);
        test_random_calm(CALM_ITEMS);
        s_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
